FILE: rtl/read_region_coalescer_top_macros.svh
// Assertion macros for the read region coalescer
`ifndef READ_REGION_COALESCER_TOP_MACROS_SVH
`define READ_REGION_COALESCER_TOP_MACROS_SVH

// same-cycle implication
`define RRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrc assertion failed");

// next-cycle implication
`define RRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrc assertion failed");

`endif

FILE: rtl/rrc_pkg.sv
// Types and constants of the read region coalescer
package rrc_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int LENGTH_BITS = 32;
  localparam int QUANT_BITS = 32;
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_INDEX_BITS = 2;

  localparam int END_BITS = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;
  localparam int DIFF_BITS = END_BITS + 1;
  localparam int SPAN_BITS = END_BITS;
  localparam int LOAD_BITS = SPAN_BITS + 1;
  localparam int ACC_BITS = LOAD_BITS + 1;
  localparam int CMP_BITS = (END_BITS > CFG_DATA_BITS) ? END_BITS : CFG_DATA_BITS;
  localparam int CNT_BITS = $clog2(SPAN_BITS);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_GAP         = 2'd0,
    REG_MAX_GROUP_BYTES = 2'd1,
    REG_LOAD_QUANTUM    = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_END,
    S_GAP,
    S_GROW,
    S_JOIN,
    S_SPAN,
    S_DIV,
    S_ADDB,
    S_ADDL,
    S_LAST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] region_offset;
    logic [LENGTH_BITS-1:0] region_length;
    logic                   last_region;
  } in_word_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] total_bytes;
    logic [OFFSET_BITS-1:0] total_loads;
    logic                   overflowed;
  } out_word_t;

endpackage

FILE: rtl/read_region_coalescer_top.sv
// Read region coalescer: merges byte regions into read groups, sums bytes and loads
//
// channel | direction | handshake          | word
// in_     | input     | in_valid/in_ready  | region_offset, region_length, last_region
// out_    | output    | out_valid/out_ready| total_bytes, total_loads, overflowed
// cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// An empty item or one that opens a group passes S_END and S_LAST; one that joins also
// passes S_GAP, S_GROW unless it overlaps, and S_JOIN. Closing a group takes the span,
// SPAN_BITS (49) steps of the shared divider and two saturating adds, also when an item
// splits the group. A last item also closes its open group, then waits in S_EMIT while
// a stalled out_ready holds the previous result; in_ready only in idle.
// Reset is synchronous: sequencer, group state and sums clear, config to defaults.
`include "read_region_coalescer_top_macros.svh"

module read_region_coalescer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rrc_pkg::in_word_t                     in_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rrc_pkg::out_word_t                    out_word,
  input  logic                                  cfg_we,
  input  logic [rrc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rrc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // config
  logic [rrc_pkg::CFG_DATA_BITS-1:0] max_gap_r;
  logic [rrc_pkg::CFG_DATA_BITS-1:0] max_group_r;
  logic [rrc_pkg::QUANT_BITS-1:0]    quantum_r;

  // sequencer and group state
  rrc_pkg::state_t                   state_r, state_nxt;
  rrc_pkg::in_word_t                 item_r, item_nxt;
  logic [rrc_pkg::END_BITS-1:0]      item_end_r, item_end_nxt;
  logic [rrc_pkg::OFFSET_BITS-1:0]   group_start_r, group_start_nxt;
  logic [rrc_pkg::END_BITS-1:0]      group_end_r, group_end_nxt;
  logic                              group_open_r, group_open_nxt;
  logic                              pend_open_r, pend_open_nxt;
  logic [rrc_pkg::OFFSET_BITS-1:0]   bytes_sum_r, bytes_sum_nxt;
  logic [rrc_pkg::OFFSET_BITS-1:0]   loads_sum_r, loads_sum_nxt;
  logic                              overflow_r, overflow_nxt;

  // divider
  logic [rrc_pkg::SPAN_BITS-1:0]     span_r, span_nxt;
  logic [rrc_pkg::SPAN_BITS-1:0]     quo_r, quo_nxt;
  logic [rrc_pkg::QUANT_BITS-1:0]    rem_r, rem_nxt;
  logic [rrc_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;

  // output
  logic                              out_valid_r, out_valid_nxt;
  rrc_pkg::out_word_t                out_word_r, out_word_nxt;

  // shared arithmetic
  logic [rrc_pkg::QUANT_BITS-1:0]    q_eff;
  logic [rrc_pkg::CFG_DATA_BITS-1:0] limit_eff;
  logic [rrc_pkg::END_BITS-1:0]      end_sum;
  logic [rrc_pkg::DIFF_BITS-1:0]     gap_diff;
  logic                              overlaps;
  logic                              gap_ok;
  logic [rrc_pkg::END_BITS-1:0]      grown;
  logic                              grown_ok;
  logic [rrc_pkg::QUANT_BITS:0]      div_shift;
  logic [rrc_pkg::QUANT_BITS+1:0]    div_trial;
  logic                              div_fits;
  logic [rrc_pkg::ACC_BITS-1:0]      add_acc, add_val, add_sum;
  logic                              add_cin;
  logic                              add_over;
  logic [rrc_pkg::OFFSET_BITS-1:0]   add_res;
  logic                              rem_below_q;
  logic                              group_ordered;
  logic                              div_more;
  logic                              emit_fire;

  assign q_eff     = (quantum_r == '0) ? rrc_pkg::QUANT_BITS'(1) : quantum_r;
  assign limit_eff = (max_group_r == '0) ? rrc_pkg::CFG_DATA_BITS'(1) : max_group_r;

  assign end_sum  = rrc_pkg::END_BITS'(item_r.region_offset)
                  + rrc_pkg::END_BITS'(item_r.region_length);
  assign gap_diff = rrc_pkg::DIFF_BITS'(item_r.region_offset)
                  - rrc_pkg::DIFF_BITS'(group_end_r);
  assign overlaps = gap_diff[rrc_pkg::DIFF_BITS-1];
  assign gap_ok   = (rrc_pkg::CMP_BITS)'(gap_diff[rrc_pkg::END_BITS-1:0])
                  <= (rrc_pkg::CMP_BITS)'(max_gap_r);
  assign grown    = item_end_r - rrc_pkg::END_BITS'(group_start_r);
  assign grown_ok = (rrc_pkg::CMP_BITS)'(grown) <= (rrc_pkg::CMP_BITS)'(limit_eff);

  assign div_shift = {rem_r, quo_r[rrc_pkg::SPAN_BITS-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, q_eff};
  assign div_fits  = !div_trial[rrc_pkg::QUANT_BITS+1];

  // one saturating adder shared by both sums
  always_comb begin
    if (state_r == rrc_pkg::S_ADDL) begin
      add_acc = rrc_pkg::ACC_BITS'(loads_sum_r);
      add_val = rrc_pkg::ACC_BITS'(quo_r);
      add_cin = (rem_r != '0);
    end else begin
      add_acc = rrc_pkg::ACC_BITS'(bytes_sum_r);
      add_val = rrc_pkg::ACC_BITS'(span_r);
      add_cin = 1'b0;
    end
  end
  assign add_sum  = add_acc + add_val + rrc_pkg::ACC_BITS'(add_cin);
  assign add_over = |add_sum[rrc_pkg::ACC_BITS-1:rrc_pkg::OFFSET_BITS];
  assign add_res  = add_over ? '1 : add_sum[rrc_pkg::OFFSET_BITS-1:0];

  assign emit_fire = (state_r == rrc_pkg::S_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r   <= '0;
      max_group_r <= rrc_pkg::CFG_DATA_BITS'(1);
      quantum_r   <= rrc_pkg::QUANT_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rrc_pkg::REG_MAX_GAP:         max_gap_r   <= cfg_data;
        rrc_pkg::REG_MAX_GROUP_BYTES: max_group_r <= cfg_data;
        rrc_pkg::REG_LOAD_QUANTUM:    quantum_r   <= cfg_data[rrc_pkg::QUANT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rrc_pkg::S_IDLE;
      group_start_r <= '0;
      group_end_r   <= '0;
      group_open_r  <= 1'b0;
      pend_open_r   <= 1'b0;
      bytes_sum_r   <= '0;
      loads_sum_r   <= '0;
      overflow_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      group_start_r <= group_start_nxt;
      group_end_r   <= group_end_nxt;
      group_open_r  <= group_open_nxt;
      pend_open_r   <= pend_open_nxt;
      bytes_sum_r   <= bytes_sum_nxt;
      loads_sum_r   <= loads_sum_nxt;
      overflow_r    <= overflow_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    item_end_r <= item_end_nxt;
    span_r     <= span_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    item_end_nxt    = item_end_r;
    group_start_nxt = group_start_r;
    group_end_nxt   = group_end_r;
    group_open_nxt  = group_open_r;
    pend_open_nxt   = pend_open_r;
    bytes_sum_nxt   = bytes_sum_r;
    loads_sum_nxt   = loads_sum_r;
    overflow_nxt    = overflow_r;
    span_nxt        = span_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_word_nxt    = out_word_r;
    in_ready        = 1'b0;

    case (state_r)
      rrc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_word;
          state_nxt = rrc_pkg::S_END;
        end
      end
      rrc_pkg::S_END: begin
        item_end_nxt = end_sum;
        if (item_r.region_length == '0) begin
          state_nxt = rrc_pkg::S_LAST;
        end else if (!group_open_r) begin
          group_start_nxt = item_r.region_offset;
          group_end_nxt   = end_sum;
          group_open_nxt  = 1'b1;
          state_nxt       = rrc_pkg::S_LAST;
        end else begin
          state_nxt = rrc_pkg::S_GAP;
        end
      end
      rrc_pkg::S_GAP: begin
        if (overlaps) begin
          state_nxt = rrc_pkg::S_JOIN;
        end else if (gap_ok) begin
          state_nxt = rrc_pkg::S_GROW;
        end else begin
          pend_open_nxt = 1'b1;
          state_nxt     = rrc_pkg::S_SPAN;
        end
      end
      rrc_pkg::S_GROW: begin
        if (grown_ok) begin
          state_nxt = rrc_pkg::S_JOIN;
        end else begin
          pend_open_nxt = 1'b1;
          state_nxt     = rrc_pkg::S_SPAN;
        end
      end
      rrc_pkg::S_JOIN: begin
        if (item_end_r > group_end_r) begin
          group_end_nxt = item_end_r;
        end
        state_nxt = rrc_pkg::S_LAST;
      end
      rrc_pkg::S_SPAN: begin
        span_nxt  = group_end_r - rrc_pkg::END_BITS'(group_start_r);
        quo_nxt   = group_end_r - rrc_pkg::END_BITS'(group_start_r);
        rem_nxt   = '0;
        cnt_nxt   = rrc_pkg::CNT_BITS'(rrc_pkg::SPAN_BITS - 1);
        state_nxt = rrc_pkg::S_DIV;
      end
      rrc_pkg::S_DIV: begin
        rem_nxt = div_fits ? div_trial[rrc_pkg::QUANT_BITS-1:0]
                           : div_shift[rrc_pkg::QUANT_BITS-1:0];
        quo_nxt = {quo_r[rrc_pkg::SPAN_BITS-2:0], div_fits};
        cnt_nxt = cnt_r - rrc_pkg::CNT_BITS'(1);
        if (cnt_r == '0) begin
          state_nxt = rrc_pkg::S_ADDB;
        end
      end
      rrc_pkg::S_ADDB: begin
        bytes_sum_nxt = add_res;
        overflow_nxt  = overflow_r || add_over;
        state_nxt     = rrc_pkg::S_ADDL;
      end
      rrc_pkg::S_ADDL: begin
        loads_sum_nxt  = add_res;
        overflow_nxt   = overflow_r || add_over;
        group_open_nxt = 1'b0;
        if (pend_open_r) begin
          group_start_nxt = item_r.region_offset;
          group_end_nxt   = item_end_r;
          group_open_nxt  = 1'b1;
          pend_open_nxt   = 1'b0;
        end
        state_nxt = rrc_pkg::S_LAST;
      end
      rrc_pkg::S_LAST: begin
        if (!item_r.last_region) begin
          state_nxt = rrc_pkg::S_IDLE;
        end else if (group_open_r) begin
          state_nxt = rrc_pkg::S_SPAN;
        end else begin
          state_nxt = rrc_pkg::S_EMIT;
        end
      end
      rrc_pkg::S_EMIT: begin
        if (emit_fire) begin
          out_word_nxt.total_bytes = bytes_sum_r;
          out_word_nxt.total_loads = loads_sum_r;
          out_word_nxt.overflowed  = overflow_r;
          out_valid_nxt            = 1'b1;
          group_start_nxt          = '0;
          group_end_nxt            = '0;
          group_open_nxt           = 1'b0;
          bytes_sum_nxt            = '0;
          loads_sum_nxt            = '0;
          overflow_nxt             = 1'b0;
          state_nxt                = rrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrc_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign rem_below_q   = rem_r < q_eff;
  assign group_ordered = group_end_r > rrc_pkg::END_BITS'(group_start_r);
  assign div_more      = (state_r == rrc_pkg::S_DIV) && (cnt_r != '0);

  `RRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `RRC_ASSERT_NOW(a_rem_below_q, clk, rst_n, state_r == rrc_pkg::S_DIV, rem_below_q)
  `RRC_ASSERT_NOW(a_group_ordered, clk, rst_n, group_open_r, group_ordered)
  `RRC_ASSERT_NEXT(a_div_runs, clk, rst_n, div_more, state_r == rrc_pkg::S_DIV)
  `RRC_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_fire, out_valid && !group_open_r && !overflow_r)

endmodule

FILE: tb/sv/rrc_totals_checker.sv
`timescale 1ns / 1ps
// Checker for the read region coalescer: mirrors group merging and compares list totals
module rrc_totals_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  rrc_pkg::in_word_t                  in_word,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  rrc_pkg::out_word_t                 out_word,
  input  logic                               cfg_we,
  input  logic [rrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rrc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               run_done,
  output int                                 fail_count
);

  localparam logic [63:0] SUM_CAP = (64'd1 << rrc_pkg::OFFSET_BITS) - 64'd1;

  logic [63:0]        cap_gap, cap_span, quantum;
  logic [63:0]        grp_start, grp_end, byte_total, load_total;
  bit                 grp_open, sat_flag, end_checked;
  rrc_pkg::out_word_t totals_q[$];
  rrc_pkg::out_word_t want;

  function automatic logic [64:0] add_capped(input logic [63:0] acc, input logic [63:0] amt);
    if (amt > SUM_CAP || acc > SUM_CAP - amt) return {1'b1, SUM_CAP};
    return {1'b0, acc + amt};
  endfunction

  task automatic clear_list();
    grp_start  = '0;
    grp_end    = '0;
    grp_open   = 1'b0;
    byte_total = '0;
    load_total = '0;
    sat_flag   = 1'b0;
  endtask

  task automatic retire_group();
    logic [63:0] span, q, loads;
    logic [64:0] sum;
    span = grp_end - grp_start;
    q = (quantum == 0) ? 64'd1 : quantum;
    loads = span / q + ((span % q != 0) ? 64'd1 : 64'd0);
    sum = add_capped(byte_total, span);
    byte_total = sum[63:0];
    sat_flag |= sum[64];
    sum = add_capped(load_total, loads);
    load_total = sum[63:0];
    sat_flag |= sum[64];
    grp_open = 1'b0;
  endtask

  task automatic absorb_region(input rrc_pkg::in_word_t w);
    logic [63:0]        off, len, fin, cap, gap, grown;
    bit                 overlaps;
    rrc_pkg::out_word_t res;
    off = 64'(w.region_offset);
    len = 64'(w.region_length);
    fin = off + len;
    if (len != 0) begin
      if (!grp_open) begin
        grp_start = off;
        grp_end   = fin;
        grp_open  = 1'b1;
      end else begin
        cap      = (cap_span == 0) ? 64'd1 : cap_span;
        overlaps = off < grp_end;
        gap      = overlaps ? 64'd0 : off - grp_end;
        grown    = overlaps ? 64'd0 : fin - grp_start;
        if (overlaps || (gap <= cap_gap && grown <= cap)) begin
          if (fin > grp_end) grp_end = fin;
        end else begin
          retire_group();
          grp_start = off;
          grp_end   = fin;
          grp_open  = 1'b1;
        end
      end
    end
    if (w.last_region) begin
      if (grp_open) retire_group();
      res.total_bytes = byte_total[rrc_pkg::OFFSET_BITS-1:0];
      res.total_loads = load_total[rrc_pkg::OFFSET_BITS-1:0];
      res.overflowed  = sat_flag;
      totals_q.insert(totals_q.size(), res);
      clear_list();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_gap     = '0;
      cap_span    = 64'd1;
      quantum     = 64'd1;
      fail_count  = 0;
      end_checked = 1'b0;
      clear_list();
      totals_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (totals_q.size() == 0) begin
          $error("unexpected totals word: %p", out_word);
          fail_count++;
        end else begin
          want = totals_q.pop_front();
          if (out_word.total_bytes !== want.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d", want.total_bytes, out_word.total_bytes);
            fail_count++;
          end
          if (out_word.total_loads !== want.total_loads) begin
            $error("total_loads: expected %0d, got %0d", want.total_loads, out_word.total_loads);
            fail_count++;
          end
          if (out_word.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, out_word.overflowed);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rrc_pkg::REG_MAX_GAP:         cap_gap  = 64'(cfg_data);
          rrc_pkg::REG_MAX_GROUP_BYTES: cap_span = 64'(cfg_data);
          rrc_pkg::REG_LOAD_QUANTUM:    quantum  = 64'(cfg_data[rrc_pkg::QUANT_BITS-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_region(in_word);
      if (run_done && !end_checked) begin
        end_checked = 1'b1;
        if (totals_q.size() != 0) begin
          $error("%0d totals words never arrived", totals_q.size());
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_read_region_coalescer_top.sv
`timescale 1ns / 1ps
// Testbench top for the read region coalescer: region lists, limit settings and verdict
module tb_read_region_coalescer_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_WORDS  = 120;
  localparam logic [47:0] OFF_MAX      = '1;
  localparam logic [31:0] LEN_MAX      = '1;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  rrc_pkg::in_word_t                  in_word;
  logic                               out_valid;
  logic                               out_ready;
  rrc_pkg::out_word_t                 out_word;
  logic                               cfg_we;
  logic [rrc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [rrc_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                               run_done;
  int                                 fail_count;

  bit          idle_on;
  bit          hold_req;
  int unsigned lists_sent;
  int unsigned results_seen;
  logic [47:0] prev_off;

  read_region_coalescer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rrc_totals_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .run_done   (run_done),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall per word, one long hold on request
  initial begin : receiver
    int unsigned stall;
    out_ready    = 1'b0;
    results_seen = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        stall = idle_on ? $urandom_range(0, 13) : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      results_seen++;
      @(negedge clk);
    end
  end

  function automatic logic [47:0] rand_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic offer_region(input logic [47:0] off, input logic [31:0] len, input bit last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{region_offset: off, region_length: len, last_region: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (last) lists_sent++;
    @(negedge clk);
  endtask

  task automatic load_limits(input logic [47:0] gap, input logic [47:0] span,
                             input logic [31:0] quant);
    cfg_we    <= 1'b1;
    cfg_index <= rrc_pkg::REG_MAX_GAP;
    cfg_data  <= gap;
    @(negedge clk);
    cfg_index <= rrc_pkg::REG_MAX_GROUP_BYTES;
    cfg_data  <= span;
    @(negedge clk);
    cfg_index <= rrc_pkg::REG_LOAD_QUANTUM;
    cfg_data  <= 48'(quant);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every list total, then let a trailing close finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (results_seen != lists_sent) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_region_list(input int unsigned count);
    logic [47:0] off;
    logic [31:0] len;
    prev_off = ($urandom_range(0, 3) == 0) ? rand_wide() : 48'($urandom_range(0, 65535));
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       off = rand_wide();
        1:       off = OFF_MAX - 48'($urandom_range(0, 1 << 20));
        2:       off = prev_off - 48'($urandom_range(0, 4096));
        default: off = prev_off + 48'($urandom_range(0, 8192));
      endcase
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = LEN_MAX;
        2, 3:    len = $urandom;
        default: len = $urandom_range(1, 4096);
      endcase
      offer_region(off, len, i == count - 1);
      prev_off = off + 48'(len);
    end
  endtask

  initial begin : stimulus
    logic [47:0] gap, span;
    logic [31:0] quant;
    int unsigned sent;
    int unsigned list_len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = rrc_pkg::REG_MAX_GAP;
    cfg_data   = '0;
    run_done   = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    lists_sent = 0;
    prev_off   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, overlap, region ahead of group start, bridged gap, split
    load_limits(48'd16, 48'd64, 32'd8);
    offer_region(48'd0, 32'd0, 1'b1);
    offer_region(48'd500, 32'd0, 1'b0);
    offer_region(48'd100, 32'd10, 1'b0);
    offer_region(48'd105, 32'd20, 1'b0);
    offer_region(48'd90, 32'd5, 1'b0);
    offer_region(48'd135, 32'd4, 1'b0);
    offer_region(48'd200, 32'd8, 1'b1);
    offer_region(OFF_MAX, LEN_MAX, 1'b0);
    offer_region(48'd0, 32'd1, 1'b1);
    settle_block();

    // widest limits, quantum zero, regions near the top of the offset range, then a new list
    load_limits(OFF_MAX, OFF_MAX, 32'd0);
    offer_region(48'd0, 32'd1, 1'b0);
    offer_region(OFF_MAX - 48'(LEN_MAX) + 48'd1, LEN_MAX, 1'b0);
    offer_region(OFF_MAX - 48'd1, LEN_MAX, 1'b1);
    offer_region(48'd7, 32'd3, 1'b1);
    settle_block();

    // span limit zero acts as one, widest quantum
    load_limits(48'd0, 48'd0, LEN_MAX);
    offer_region(48'd10, 32'd1, 1'b0);
    offer_region(48'd11, 32'd1, 1'b0);
    offer_region(48'd11, 32'd1, 1'b0);
    offer_region(48'd12, 32'd0, 1'b0);
    offer_region(48'd20, 32'd5, 1'b1);
    settle_block();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       gap = '0;
        1:       gap = OFF_MAX;
        2:       gap = rand_wide();
        default: gap = 48'($urandom_range(0, 8192));
      endcase
      case ($urandom_range(0, 5))
        0:       span = '0;
        1:       span = OFF_MAX;
        2:       span = rand_wide();
        3:       span = 48'd1;
        default: span = 48'($urandom_range(2, 65536));
      endcase
      case ($urandom_range(0, 5))
        0:       quant = '0;
        1:       quant = LEN_MAX;
        2:       quant = $urandom;
        3:       quant = 32'd1;
        default: quant = $urandom_range(2, 4096);
      endcase
      load_limits(gap, span, quant);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        list_len = $urandom_range(1, 12);
        send_region_list(list_len);
        sent += list_len;
      end
      settle_block();
    end

    run_done <= 1'b1;
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
